FILE: rtl/wrp_pkg.sv
// shared types and constants for the well512 random generator
package wrp_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned PoolN  = 16;
    localparam int unsigned PosW   = 4;
    localparam int unsigned CntW   = 5;

    localparam logic [WordW-1:0] Temper = 32'hDA44_2D20;

    localparam logic [PosW-1:0] OffC1 = 4'd13;
    localparam logic [PosW-1:0] OffC2 = 4'd9;
    localparam logic [PosW-1:0] OffPrev = 4'd15;
    localparam logic [CntW-1:0] DivLast = 5'd31;

    // word kinds
    localparam logic KindSeed = 1'b0;
    localparam logic KindDraw = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_C1,
        ST_RD_C2,
        ST_RD_PREV,
        ST_WRITE_W,
        ST_DIVIDE,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        RD_POS,
        RD_C1,
        RD_C2,
        RD_PREV
    } t_rd_sel;

    typedef struct packed {
        logic    seed_wr;
        logic    load_lim;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cap_a;
        logic    cap_b;
        logic    wr_a;
        logic    wr_w;
        logic    div_step;
    } t_dp_cmd;

    typedef struct packed {
        logic lim_zero;
        logic div_last;
    } t_dp_status;

endpackage

FILE: rtl/wrp_ram.sv
// generic single write, single read ram with registered read data
module wrp_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/wrp_ctrl.sv
// control state machine sequencing pool reads, writes and the remainder steps
module wrp_ctrl import wrp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       i_kind,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       busy,
    output logic       o_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start && (i_kind == KindDraw)) begin
                    n_state = ST_RD_C1;
                end
            end
            ST_RD_C1:   n_state = ST_RD_C2;
            ST_RD_C2:   n_state = ST_RD_PREV;
            ST_RD_PREV: n_state = ST_WRITE_W;
            ST_WRITE_W: begin
                n_state = i_status.lim_zero ? ST_DONE : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (i_status.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_valid = 1'b0;
        busy    = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy           = 1'b0;
                o_cmd.seed_wr  = start && (i_kind == KindSeed);
                o_cmd.load_lim = start && (i_kind == KindDraw);
                o_cmd.rd_en    = start && (i_kind == KindDraw);
                o_cmd.rd_sel   = RD_POS;
            end
            ST_RD_C1: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_C1;
                o_cmd.cap_a  = 1'b1;
            end
            ST_RD_C2: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_C2;
                o_cmd.cap_b  = 1'b1;
            end
            ST_RD_PREV: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_PREV;
                o_cmd.wr_a   = 1'b1;
            end
            ST_WRITE_W: o_cmd.wr_w     = 1'b1;
            ST_DIVIDE:  o_cmd.div_step = 1'b1;
            ST_DONE:    o_valid        = 1'b1;
            default:    busy           = 1'b1;
        endcase
    end

endmodule

FILE: rtl/wrp_dp.sv
// datapath: pool memory, well512 step registers and bit-serial remainder
module wrp_dp import wrp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [PosW-1:0]   i_seed_slot,
    input  logic [WordW-1:0]  i_seed_word,
    input  logic [WordW-1:0]  i_range_limit,
    output t_dp_status        o_status,
    output logic [WordW-1:0]  o_random_value
);

    logic [PosW-1:0]  r_pos;
    logic [PoolN-1:0] r_valid;
    logic             r_rd_ok;
    logic [WordW-1:0] r_a, r_b, r_c, r_d, r_lim, r_dvd, r_rem;
    logic [CntW-1:0]  r_cnt;

    logic [PosW-1:0]  rd_addr, wr_addr, pos_prev;
    logic [WordW-1:0] wr_data, ram_q, q_m, c_mix, new_a, w_val;
    logic             we;
    logic [WordW:0]   rem_sh, diff;

    assign pos_prev = r_pos + OffPrev;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_POS:  rd_addr = r_pos;
            RD_C1:   rd_addr = r_pos + OffC1;
            RD_C2:   rd_addr = r_pos + OffC2;
            RD_PREV: rd_addr = pos_prev;
            default: rd_addr = r_pos;
        endcase
    end

    // words never written since reset read as zero
    assign q_m   = r_rd_ok ? ram_q : '0;
    assign c_mix = q_m ^ (q_m >> 11);
    assign new_a = r_b ^ c_mix;
    assign w_val = q_m ^ r_b ^ r_d ^ (q_m << 2) ^ (r_b << 18) ^ (r_c << 28);

    always_comb begin
        we      = 1'b1;
        wr_addr = i_seed_slot;
        wr_data = i_seed_word;
        if (i_cmd.wr_a) begin
            wr_addr = r_pos;
            wr_data = new_a;
        end else if (i_cmd.wr_w) begin
            wr_addr = pos_prev;
            wr_data = w_val;
        end else if (!i_cmd.seed_wr) begin
            we = 1'b0;
        end
    end

    wrp_ram #(
        .Width (WordW),
        .Depth (PoolN)
    ) u_pool (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    assign rem_sh = {r_rem, r_dvd[WordW-1]};
    assign diff   = rem_sh - {1'b0, r_lim};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= '0;
            r_rd_ok <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (we) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_ok <= r_valid[rd_addr];
            end
            if (i_cmd.seed_wr) begin
                r_pos <= '0;
            end else if (i_cmd.wr_w) begin
                r_pos <= pos_prev;
            end
            if (i_cmd.wr_w) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_lim) begin
            r_lim <= i_range_limit;
        end
        if (i_cmd.cap_a) begin
            r_a <= q_m;
        end
        if (i_cmd.cap_b) begin
            r_b <= r_a ^ q_m ^ (r_a << 16) ^ (q_m << 15);
        end
        if (i_cmd.wr_a) begin
            r_c <= c_mix;
            r_d <= new_a ^ ((new_a << 5) & Temper);
        end
        if (i_cmd.wr_w) begin
            r_dvd <= w_val;
            r_rem <= (r_lim == '0) ? w_val : '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_rem <= diff[WordW] ? rem_sh[WordW-1:0] : diff[WordW-1:0];
        end
    end

    assign o_status.lim_zero = (r_lim == '0);
    assign o_status.div_last = (r_cnt == DivLast);
    assign o_random_value    = r_rem;

endmodule

FILE: rtl/well512_random_generator.sv
// top level of the well512 random generator
// A word is accepted when start is high and busy is low. kind 0 writes
// seed_word into pool slot seed_slot and zeroes the read position in that one
// cycle, giving no result. kind 1 runs one well512 step and returns one word on
// o_random_value, marked by o_valid for exactly one cycle; the receiver cannot
// stall it, so it must take the word in that cycle. A draw with range_limit 0
// steps through RD_C1, RD_C2, RD_PREV, WRITE_W and DONE; a nonzero limit adds
// the DIVIDE state for the restoring remainder, one quotient bit per cycle,
// before DONE. The four pool reads go one at a time through the single read
// port of the pool ram. The pool reads as all zeros after reset until slots
// are seeded.
module well512_random_generator import wrp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_kind,
    input  logic [PosW-1:0]  i_seed_slot,
    input  logic [WordW-1:0] i_seed_word,
    input  logic [WordW-1:0] i_range_limit,
    output logic             o_valid,
    output logic [WordW-1:0] o_random_value
);

    // command and status between the sequencer and the datapath
    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencer: issues seed writes, walks the reads and writes of one draw, then the remainder steps
    wrp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_kind   (i_kind),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_valid  (o_valid)
    );

    // datapath: pool ram, mixing registers and the remainder unit
    wrp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_seed_slot    (i_seed_slot),
        .i_seed_word    (i_seed_word),
        .i_range_limit  (i_range_limit),
        .o_status       (status),
        .o_random_value (o_random_value)
    );

endmodule

FILE: bench/tb_well512_random_generator.sv
// self-checking testbench for the well512 random generator: seeded draws against a local model
`timescale 1ns / 1ps

module tb_well512_random_generator import wrp_pkg::*; ();

    // about 1900 items in the random part
    localparam int unsigned RandomItems = 1900;
    // margin after the last result, longer than a draw with a nonzero limit
    localparam int unsigned DrainCycles = 48;
    // timeout in ns, with the 2 ns clock period
    localparam longint unsigned TimeoutNs = 64'd2_000_000;

    typedef struct {
        logic             kind;
        logic [PosW-1:0]  slot;
        logic [WordW-1:0] seed;
        logic [WordW-1:0] limit;
    } t_gen_cmd;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic             i_kind = KindSeed;
    logic [PosW-1:0]  i_seed_slot = '0;
    logic [WordW-1:0] i_seed_word = '0;
    logic [WordW-1:0] i_range_limit = '0;
    logic             o_valid;
    logic [WordW-1:0] o_random_value;

    well512_random_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_seed_slot    (i_seed_slot),
        .i_seed_word    (i_seed_word),
        .i_range_limit  (i_range_limit),
        .o_valid        (o_valid),
        .o_random_value (o_random_value)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // synchronous reset, released once and never asserted again
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // model state: pool of sixteen words and the 4-bit position
    // ------------------------------------------------------------------
    logic [WordW-1:0] pool_model [PoolN];
    logic [PosW-1:0]  pos_model = '0;

    t_gen_cmd         pending_cmds [$];
    logic [WordW-1:0] expected_words [$];
    t_gen_cmd         cur_cmd;
    int unsigned      total_cmds = 0;
    int unsigned      accepted_cnt = 0;
    int unsigned      mismatch_cnt = 0;
    int unsigned      burst_left = 0;
    int unsigned      gap_left = 0;

    initial begin
        for (int i = 0; i < PoolN; i++) pool_model[i] = '0;
    end

    // one well512 step on the model pool, returns the freshly written word
    function automatic logic [WordW-1:0] well_advance();
        logic [PosW-1:0]  p;
        logic [PosW-1:0]  p_c1;
        logic [PosW-1:0]  p_c2;
        logic [WordW-1:0] a;
        logic [WordW-1:0] b;
        logic [WordW-1:0] c;
        logic [WordW-1:0] d;
        logic [WordW-1:0] w;
        p    = pos_model;
        p_c1 = p + OffC1;
        p_c2 = p + OffC2;
        a = pool_model[p];
        c = pool_model[p_c1];
        b = a ^ c ^ (a << 16) ^ (c << 15);
        c = pool_model[p_c2];
        c = c ^ (c >> 11);
        a = b ^ c;
        pool_model[p] = a;
        d = a ^ ((a << 5) & Temper);
        // step back one slot, the previous word gets the output value
        p = p + OffPrev;
        pos_model = p;
        a = pool_model[p];
        w = a ^ b ^ d ^ (a << 2) ^ (b << 18) ^ (c << 28);
        pool_model[p] = w;
        return w;
    endfunction

    // apply an accepted word to the model, queue the result it should give
    function automatic void predict_cmd(t_gen_cmd cmd);
        logic [WordW-1:0] r;
        if (cmd.kind == KindSeed) begin
            // seed write also rewinds the position
            pool_model[cmd.slot] = cmd.seed;
            pos_model = '0;
        end else begin
            r = well_advance();
            // zero limit returns the raw word
            if (cmd.limit != '0) r = r % cmd.limit;
            expected_words.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // driver: bursts of words with random gaps; start stays up until taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drv_proc
        logic nstart;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            nstart = start;
            if (start && !busy) begin
                predict_cmd(cur_cmd);
                accepted_cnt++;
                nstart = 1'b0;
            end
            if (!nstart) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_cmds.size() != 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    i_kind        <= cur_cmd.kind;
                    i_seed_slot   <= cur_cmd.slot;
                    i_seed_word   <= cur_cmd.seed;
                    i_range_limit <= cur_cmd.limit;
                    nstart = 1'b1;
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        // new burst; a third of the time no gap at all
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
                    end
                end
            end
            start <= nstart;
        end
    end

    // ------------------------------------------------------------------
    // monitor: every strobed result must match the oldest expected word
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : mon_proc
        logic [WordW-1:0] exp_word;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_random_value);
                mismatch_cnt++;
            end else begin
                exp_word = expected_words.pop_front();
                if (o_random_value !== exp_word) begin
                    $display("%0t: random_value mismatch, expected %h, actual %h",
                             $time, exp_word, o_random_value);
                    mismatch_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_cmd(logic kind, logic [PosW-1:0] slot,
                           logic [WordW-1:0] seed, logic [WordW-1:0] limit);
        t_gen_cmd cmd;
        cmd.kind  = kind;
        cmd.slot  = slot;
        cmd.seed  = seed;
        cmd.limit = limit;
        pending_cmds.push_back(cmd);
    endtask

    // draw with junk in the seed fields, which the block ignores
    task automatic add_draw(logic [WordW-1:0] limit);
        add_cmd(KindDraw, PosW'($urandom_range(0, PoolN - 1)), $urandom, limit);
    endtask

    // limits weighted toward the interesting corners of the remainder
    function automatic logic [WordW-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return $urandom_range(1, 16);
            2: return 32'h1 << $urandom_range(0, 31);
            3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            4: return $urandom_range(1, 1000);
            5: return 32'h8000_0000 | $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WordW-1:0] pick_seed();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stim_proc
        int unsigned      n;
        int unsigned      draws;
        logic [PosW-1:0]  order [PoolN];
        logic [PosW-1:0]  tmp;
        int unsigned      j;

        // unseeded pool: draws give zero, raw and reduced
        add_draw('0);
        add_draw(32'hFFFF_FFFF);
        // seed every slot, slots 0, 1, 8 and 15 with extremes and the rest random; range_limit on a seed is ignored
        for (int s = 0; s < PoolN; s++) begin
            case (s)
                0, 15:   add_cmd(KindSeed, PosW'(s), 32'hFFFF_FFFF, $urandom);
                1:       add_cmd(KindSeed, PosW'(s), 32'h0000_0000, 32'h0);
                8:       add_cmd(KindSeed, PosW'(s), 32'h8000_0000, $urandom);
                default: add_cmd(KindSeed, PosW'(s), $urandom, $urandom);
            endcase
        end
        // raw word, then the limit corners
        add_draw('0);
        add_draw(32'h1);
        add_draw(32'h2);
        add_draw(32'h8000_0000);
        add_draw(32'hFFFF_FFFF);
        add_draw(32'h7);

        n = 0;
        while (n < RandomItems) begin
            case ($urandom_range(0, 9))
                0: begin
                    // noise: anything the fields allow
                    add_cmd(1'($urandom_range(0, 1)), PosW'($urandom_range(0, PoolN - 1)),
                            $urandom, pick_limit());
                    n++;
                end
                1: begin
                    // single reseed mid-stream, rewinds the position
                    add_cmd(KindSeed, PosW'($urandom_range(0, PoolN - 1)), pick_seed(),
                            $urandom);
                    draws = $urandom_range(1, 6);
                    for (int k = 0; k < draws; k++) add_draw(pick_limit());
                    n += 1 + draws;
                end
                default: begin
                    // full reseed in shuffled slot order, then a run of draws
                    for (int s = 0; s < PoolN; s++) order[s] = PosW'(s);
                    for (int s = PoolN - 1; s > 0; s--) begin
                        j = $urandom_range(0, s);
                        tmp = order[s];
                        order[s] = order[j];
                        order[j] = tmp;
                    end
                    for (int s = 0; s < PoolN; s++)
                        add_cmd(KindSeed, order[s], pick_seed(), $urandom);
                    draws = $urandom_range(8, 40);
                    for (int k = 0; k < draws; k++) add_draw(pick_limit());
                    n += PoolN + draws;
                end
            endcase
        end
        total_cmds = pending_cmds.size();

        // wait for every word to be taken and every result to come back
        @(posedge i_rst_n);
        while (!(accepted_cnt == total_cmds && expected_words.size() == 0))
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(TimeoutNs);
        $display("%0t: timeout", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule
